// ===== rtl/core/circular_list_cursor_engine_unit_macros.svh =====
// Assertion macros used by the list engine datapath.
// Both macros sample on the rising edge of clk_i and are disabled during reset.
`ifndef CIRCULAR_LIST_CURSOR_ENGINE_UNIT_MACROS_SVH
`define CIRCULAR_LIST_CURSOR_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CLCE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CLCE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLCE_ASSERT(name, prop, msg)
`define CLCE_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== rtl/core/clce_pkg.sv =====
package clce_pkg;

  // Default sizing of the node pool.
  localparam int unsigned POOL_DEPTH_DEF  = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Fixed port field widths.
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Action codes; the two unused codes behave as a count request.
  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_PREPEND = 3'd1,
    ACT_FIRST   = 3'd2,
    ACT_NEXT    = 3'd3,
    ACT_REMOVE  = 3'd4,
    ACT_COUNT   = 3'd5
  } clce_action_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_CURSOR = 2'd3
  } clce_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load;        // capture the item value of an accepted transfer
    logic         stack_pop;   // read and pop the recycle stack
    logic         alloc;       // write the new node and link it behind the tail
    logic         link_new;    // close the ring through the new node
    logic         at_tail;     // new node becomes the tail, else the head
    logic         cur_first;   // cursor to the head, read its value
    logic         link_fetch;  // read link and value at the cursor
    logic         cur_adv;     // cursor to the fetched link, read its value
    logic         remove;      // unlink the cursor node and recycle it
    logic         respond;     // load the result registers and strobe
    logic         resp_value;  // result carries the last value read
    clce_status_e resp_status;
  } clce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic nonempty;
    logic cursor_valid;
    logic can_grab;
    logic recycled_avail;
  } clce_stat_t;

endpackage

// ===== rtl/core/clce_datapath.sv =====
module clce_datapath #(
  parameter int unsigned POOL_DEPTH  = clce_pkg::POOL_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = clce_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [clce_pkg::ITEM_W-1:0]   item_value_i,
  input  clce_pkg::clce_cmd_t           cmd_i,
  output clce_pkg::clce_stat_t          stat_o,
  output logic                          done_o,
  output logic [clce_pkg::STATUS_W-1:0] status_o,
  output logic [clce_pkg::ITEM_W-1:0]   read_value_o,
  output logic [clce_pkg::COUNT_W-1:0]  count_o
);

  `include "circular_list_cursor_engine_unit_macros.svh"

  localparam int unsigned IDX_W = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);

  // Node pool and recycle stack memories.
  logic [VALUE_WIDTH-1:0] value_mem [POOL_DEPTH];
  logic [IDX_W-1:0]       link_mem  [POOL_DEPTH];
  logic [IDX_W-1:0]       stack_mem [POOL_DEPTH];

  // List control state.
  logic [IDX_W-1:0] tail_q, head_q, cursor_q, prior_q;
  logic             nonempty_q, cursor_valid_q, from_stack_q, done_q;
  logic [CNT_W-1:0] count_q, top_q, fresh_q;

  // Payload registers.
  logic [VALUE_WIDTH-1:0]          item_q, value_rd_q;
  logic [IDX_W-1:0]                node_q, link_rd_q, stack_rd_q;
  logic [clce_pkg::STATUS_W-1:0]   status_q;
  logic [clce_pkg::ITEM_W-1:0]     read_value_q;
  logic [clce_pkg::COUNT_W-1:0]    count_out_q;

  logic [CNT_W-1:0] top_dec;
  logic             top_room;
  logic [IDX_W-1:0] new_node;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr, link_wdata;
  logic             value_re;
  logic [IDX_W-1:0] value_raddr;
  logic             rm_at_tail, rm_last, rm_tail_is_prior;

  // Allocation: recycled nodes first, then never-used slots.
  assign top_dec  = top_q - CNT_W'(1);
  assign top_room = top_q < CNT_W'(POOL_DEPTH);
  assign new_node = from_stack_q ? stack_rd_q : fresh_q[IDX_W-1:0];

  // Removal cases.
  assign rm_at_tail       = cursor_q == tail_q;
  assign rm_last          = rm_at_tail && (link_rd_q == cursor_q);
  assign rm_tail_is_prior = rm_at_tail || (prior_q == tail_q);

  // Link memory write port selection.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = new_node;
    link_wdata = new_node;
    if (cmd_i.alloc) begin
      link_we    = 1'b1;
      link_waddr = nonempty_q ? tail_q : new_node;
    end else if (cmd_i.link_new) begin
      link_we    = 1'b1;
      link_waddr = node_q;
      link_wdata = head_q;
    end else if (cmd_i.remove) begin
      link_we    = 1'b1;
      link_waddr = prior_q;
      link_wdata = link_rd_q;
    end
  end

  // Value memory read address selection.
  assign value_re = cmd_i.cur_first || cmd_i.cur_adv || cmd_i.link_fetch;
  always_comb begin
    priority if (cmd_i.cur_first) begin
      value_raddr = head_q;
    end else if (cmd_i.cur_adv) begin
      value_raddr = link_rd_q;
    end else begin
      value_raddr = cursor_q;
    end
  end

  // Memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      value_mem[new_node] <= item_q;
    end
    if (value_re) begin
      value_rd_q <= value_mem[value_raddr];
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd_i.link_fetch) begin
      link_rd_q <= link_mem[cursor_q];
    end
    if (cmd_i.remove && top_room) begin
      stack_mem[top_q[IDX_W-1:0]] <= cursor_q;
    end
    if (cmd_i.stack_pop) begin
      stack_rd_q <= stack_mem[top_dec[IDX_W-1:0]];
    end
  end

  // Payload capture and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= VALUE_WIDTH'(item_value_i);
    end
    if (cmd_i.alloc) begin
      node_q <= new_node;
    end
    if (cmd_i.respond) begin
      status_q     <= cmd_i.resp_status;
      read_value_q <= cmd_i.resp_value ? clce_pkg::ITEM_W'(value_rd_q) : '0;
      count_out_q  <= clce_pkg::COUNT_W'(count_q);
    end
  end

  // List pointers, counters and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q         <= '0;
      head_q         <= '0;
      cursor_q       <= '0;
      prior_q        <= '0;
      nonempty_q     <= 1'b0;
      cursor_valid_q <= 1'b0;
      from_stack_q   <= 1'b0;
      count_q        <= '0;
      top_q          <= '0;
      fresh_q        <= '0;
      done_q         <= 1'b0;
    end else begin
      done_q <= cmd_i.respond;
      if (cmd_i.load) begin
        from_stack_q <= 1'b0;
      end
      if (cmd_i.stack_pop) begin
        top_q        <= top_dec;
        from_stack_q <= 1'b1;
      end
      if (cmd_i.alloc) begin
        count_q        <= count_q + CNT_W'(1);
        cursor_valid_q <= 1'b0;
        if (!from_stack_q) begin
          fresh_q <= fresh_q + CNT_W'(1);
        end
        if (!nonempty_q) begin
          tail_q     <= new_node;
          head_q     <= new_node;
          nonempty_q <= 1'b1;
        end
      end
      if (cmd_i.link_new) begin
        if (cmd_i.at_tail) begin
          tail_q <= node_q;
        end else begin
          head_q <= node_q;
        end
      end
      if (cmd_i.cur_first) begin
        prior_q        <= tail_q;
        cursor_q       <= head_q;
        cursor_valid_q <= 1'b1;
      end
      if (cmd_i.cur_adv) begin
        prior_q        <= cursor_q;
        cursor_q       <= link_rd_q;
        cursor_valid_q <= 1'b1;
      end
      if (cmd_i.remove) begin
        if (rm_last) begin
          nonempty_q <= 1'b0;
        end else if (rm_at_tail) begin
          tail_q <= prior_q;
        end
        if (rm_tail_is_prior) begin
          head_q <= link_rd_q;
        end
        cursor_q       <= prior_q;
        cursor_valid_q <= 1'b0;
        if (top_room) begin
          top_q <= top_q + CNT_W'(1);
        end
        if (count_q != '0) begin
          count_q <= count_q - CNT_W'(1);
        end
      end
    end
  end

  // Status toward the controller.
  assign stat_o.nonempty       = nonempty_q;
  assign stat_o.cursor_valid   = cursor_valid_q;
  assign stat_o.recycled_avail = top_q != '0;
  assign stat_o.can_grab       = (top_q != '0) || (fresh_q < CNT_W'(POOL_DEPTH));

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = read_value_q;
  assign count_o      = count_out_q;

  // Consistency checks on the list state.
  `CLCE_ASSERT(a_count_matches_list, nonempty_q == (count_q != '0), "count and list flag disagree")
  `CLCE_ASSERT(a_cursor_in_list, cursor_valid_q |-> nonempty_q, "valid cursor on an empty list")
  `CLCE_ASSERT(a_remove_has_cursor, cmd_i.remove |-> (cursor_valid_q && nonempty_q), "remove without cursor")
  `CLCE_ASSERT_NEXT(a_single_strobe, done_q, !done_q, "result strobe held for two cycles")

endmodule

// ===== rtl/core/clce_ctrl.sv =====
module clce_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [clce_pkg::ACTION_W-1:0] action_i,
  input  clce_pkg::clce_stat_t          stat_i,
  output clce_pkg::clce_cmd_t           cmd_o,
  output logic                          busy
);

  // Controller states.
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FETCH  = 8'b0000_0010,
    S_ALLOC  = 8'b0000_0100,
    S_LINK   = 8'b0000_1000,
    S_STEP   = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_REMOVE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } clce_state_e;

  clce_state_e                   state_q, state_d;
  logic [clce_pkg::ACTION_W-1:0] op_q;

  assign busy = state_q != S_IDLE;

  // Next state and datapath commands.
  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.resp_status = clce_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_FETCH;
        end
      end
      S_FETCH: begin
        unique case (op_q)
          clce_pkg::ACT_APPEND, clce_pkg::ACT_PREPEND: begin
            if (!stat_i.can_grab) begin
              cmd_o.respond     = 1'b1;
              cmd_o.resp_status = clce_pkg::ST_FULL;
              state_d           = S_IDLE;
            end else begin
              cmd_o.stack_pop = stat_i.recycled_avail;
              state_d         = S_ALLOC;
            end
          end
          clce_pkg::ACT_FIRST, clce_pkg::ACT_NEXT: begin
            if (!stat_i.nonempty) begin
              cmd_o.respond     = 1'b1;
              cmd_o.resp_status = clce_pkg::ST_EMPTY;
              state_d           = S_IDLE;
            end else if ((op_q == clce_pkg::ACT_FIRST) || !stat_i.cursor_valid) begin
              cmd_o.cur_first = 1'b1;
              state_d         = S_READ;
            end else begin
              cmd_o.link_fetch = 1'b1;
              state_d          = S_STEP;
            end
          end
          clce_pkg::ACT_REMOVE: begin
            if (!stat_i.nonempty) begin
              cmd_o.respond     = 1'b1;
              cmd_o.resp_status = clce_pkg::ST_EMPTY;
              state_d           = S_IDLE;
            end else if (!stat_i.cursor_valid) begin
              cmd_o.respond     = 1'b1;
              cmd_o.resp_status = clce_pkg::ST_NO_CURSOR;
              state_d           = S_IDLE;
            end else begin
              cmd_o.link_fetch = 1'b1;
              state_d          = S_REMOVE;
            end
          end
          default: begin
            // Count request and unused codes only report the count.
            cmd_o.respond = 1'b1;
            state_d       = S_IDLE;
          end
        endcase
      end
      S_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d     = stat_i.nonempty ? S_LINK : S_DONE;
      end
      S_LINK: begin
        cmd_o.link_new = 1'b1;
        cmd_o.at_tail  = op_q == clce_pkg::ACT_APPEND;
        cmd_o.respond  = 1'b1;
        state_d        = S_IDLE;
      end
      S_STEP: begin
        cmd_o.cur_adv = 1'b1;
        state_d       = S_READ;
      end
      S_READ: begin
        cmd_o.respond    = 1'b1;
        cmd_o.resp_value = 1'b1;
        state_d          = S_IDLE;
      end
      S_REMOVE: begin
        cmd_o.remove = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        cmd_o.respond    = 1'b1;
        cmd_o.resp_value = op_q == clce_pkg::ACT_REMOVE;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register and the action of the accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= clce_pkg::ACT_COUNT;
    end else begin
      state_q <= state_d;
      if (cmd_o.load) begin
        op_q <= action_i;
      end
    end
  end

endmodule

// ===== rtl/core/circular_list_cursor_engine_unit.sv =====
// Each action starts in S_FETCH, where count requests and errors respond; cursor first, or
// a cursor step with no valid cursor, reads in S_READ; a cursor step goes through S_STEP
// and S_READ; append and prepend go through S_ALLOC, then S_LINK or S_DONE; remove goes
// through S_REMOVE, then S_DONE. A new action is taken only in S_IDLE, after the last one
// responds. Results are shown for one cycle on done_o; the receiver cannot stall.
// Asynchronous active-low reset empties the list and invalidates the cursor.
module circular_list_cursor_engine_unit #(
  parameter int unsigned POOL_DEPTH  = clce_pkg::POOL_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = clce_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [clce_pkg::ACTION_W-1:0] action_i,
  input  logic [clce_pkg::ITEM_W-1:0]   item_value_i,
  output logic                          done_o,
  output logic [clce_pkg::STATUS_W-1:0] status_o,
  output logic [clce_pkg::ITEM_W-1:0]   read_value_o,
  output logic [clce_pkg::COUNT_W-1:0]  count_o
);

  clce_pkg::clce_cmd_t  cmd;
  clce_pkg::clce_stat_t stat;

  // Sequencer for each action.
  clce_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Node pool, list pointers and result registers.
  clce_datapath #(
    .POOL_DEPTH  (POOL_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_value_i (item_value_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

endmodule
